FILE: rtl/core/dce_pkg.sv
// Shared types, field widths and codes of the distinct choice enumerator.
package dce_pkg;

    // Widths of the transaction fields and of the register.
    localparam int ACTION_W    = 2;
    localparam int SLOT_FLD_W  = 3;
    localparam int INDEX_W     = 4;
    localparam int OUT_VAL_W   = 16;
    localparam int ITER_W      = 32;
    localparam int CFG_W       = 4;

    // Per-slot option count (up to sixteen) and odometer digit (may reach the count).
    localparam int OPT_CNT_W   = 5;
    localparam int DIGIT_W     = 5;

    // Input action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_NEXT  = 2'd2
    } action_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_STEP,
        ST_CARRY,
        ST_RD,
        ST_CMP,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;     // store the loaded option entry
        logic start_init;  // clear digits and advance counter
        logic adv_init;    // count one advance, point at the last slot
        logic set_done;
        logic clr_done;
        logic step;        // bump the digit at the pointer, clear the digits after it
        logic carry;       // clear the digit at the pointer, bump the one before it
        logic wrap;        // clear all digits after the last assignment
        logic ci_clr;      // restart the duplicate scan at slot zero
        logic rd_issue;    // read the chosen value of the scanned slot
        logic cmp_take;    // keep the read value and move to the next slot
        logic dup_to_p;    // restart stepping at the duplicate slot
        logic emit_clr;    // restart result output at slot zero
        logic emit_load;   // load one result into the output register
    } dce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_empty;   // an active slot has no options, or no slot is active
        logic digit_ovf;   // digit at the pointer reached its slot's count
        logic p_zero;      // the pointer is at slot zero
        logic dup_hit;     // read value equals the value of an earlier slot
        logic ci_last;     // scan is at the last active slot
        logic done;        // enumeration is exhausted
        logic out_free;    // output register can take a result
        logic emit_last;   // the next result closes the response
    } dce_status_t;

endpackage

FILE: rtl/core/dce_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: rtl/core/dce_ctrl.sv
// Controller state machine that sequences loads, starts, advances and result output.
module dce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  dce_pkg::dce_status_t status,
    output dce_pkg::dce_cmd_t    cmd
);
    import dce_pkg::*;

    state_t state_reg, state_next;
    logic   from_start_reg, from_start_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            from_start_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            from_start_reg <= from_start_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        from_start_next = from_start_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_LOAD: begin
                            cmd.load_wr = 1'b1;
                        end
                        ACT_START: begin
                            cmd.start_init = 1'b1;
                            if (status.any_empty) begin
                                cmd.set_done = 1'b1;
                                cmd.emit_clr = 1'b1;
                                state_next   = ST_EMIT;
                            end else begin
                                // The all-zero assignment is checked first.
                                cmd.clr_done    = 1'b1;
                                cmd.ci_clr      = 1'b1;
                                from_start_next = 1'b1;
                                state_next      = ST_RD;
                            end
                        end
                        ACT_NEXT: begin
                            if (status.done) begin
                                cmd.emit_clr = 1'b1;
                                state_next   = ST_EMIT;
                            end else begin
                                state_next = ST_ADV;
                            end
                        end
                        default: begin
                            // Unused action: the transaction is dropped.
                        end
                    endcase
                end
            end
            ST_ADV: begin
                cmd.adv_init    = 1'b1;
                from_start_next = 1'b0;
                if (status.any_empty) begin
                    cmd.set_done = 1'b1;
                    cmd.emit_clr = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_CARRY;
            end
            ST_CARRY: begin
                // One digit of carry per cycle, moving toward slot zero.
                if (status.digit_ovf) begin
                    if (status.p_zero) begin
                        cmd.set_done = 1'b1;
                        cmd.wrap     = 1'b1;
                        cmd.emit_clr = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        cmd.carry = 1'b1;
                    end
                end else begin
                    cmd.ci_clr = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                priority if (status.dup_hit) begin
                    if (from_start_reg) begin
                        state_next = ST_ADV;
                    end else begin
                        cmd.dup_to_p = 1'b1;
                        state_next   = ST_STEP;
                    end
                end else if (status.ci_last) begin
                    cmd.cmp_take = 1'b1;
                    cmd.emit_clr = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    cmd.cmp_take = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dce_datapath.sv
// Datapath: option table, option counts, odometer digits, duplicate scan and output register.
module dce_datapath #(
    parameter int MAX_SLOTS   = 8,
    parameter int MAX_OPTIONS = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dce_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [dce_pkg::SLOT_FLD_W-1:0]  s_slot,
    input  logic [dce_pkg::INDEX_W-1:0]     s_option_index,
    input  logic [dce_pkg::OUT_VAL_W-1:0]   s_option_value,
    input  logic                            s_closes_slot,
    input  dce_pkg::dce_cmd_t               cmd,
    output dce_pkg::dce_status_t            status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dce_pkg::SLOT_FLD_W-1:0]  m_out_slot,
    output logic [dce_pkg::INDEX_W-1:0]     m_chosen_index,
    output logic [dce_pkg::OUT_VAL_W-1:0]   m_chosen_value,
    output logic                            m_last_of_run,
    output logic                            m_exhausted,
    output logic [dce_pkg::ITER_W-1:0]      m_iteration_count
);
    import dce_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OPT_W  = $clog2(MAX_OPTIONS);
    localparam int NSL_W  = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W = SLOT_W + OPT_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // Configuration and enumeration state.
    logic [CFG_W-1:0]      slot_count_reg;
    logic [OPT_CNT_W-1:0]  count_reg [MAX_SLOTS];
    logic [OPT_CNT_W-1:0]  count_next [MAX_SLOTS];
    logic [DIGIT_W-1:0]    digit_reg [MAX_SLOTS];
    logic [DIGIT_W-1:0]    digit_next [MAX_SLOTS];
    logic [VALUE_BITS-1:0] val_reg [MAX_SLOTS];
    logic                  done_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic [SLOT_W-1:0]     p_reg, p_next;
    logic [SLOT_W-1:0]     ci_reg;
    logic [SLOT_W-1:0]     es_reg;
    logic                  rd_oob_reg;

    // Active slot count, clamped to the slot capacity.
    logic [4:0]        sc_wide;
    logic [NSL_W-1:0]  n_act;
    logic [SLOT_W-1:0] n_last;
    logic [SLOT_W-1:0] p_dec;

    assign sc_wide = 5'(slot_count_reg);
    assign n_act   = (sc_wide > 5'(MAX_SLOTS)) ? NSL_W'(MAX_SLOTS) : NSL_W'(sc_wide);
    assign n_last  = SLOT_W'(n_act - NSL_W'(1));
    assign p_dec   = p_reg - SLOT_W'(1);

    // Load address and data.
    logic [7:0]            ld_slot_wide;
    logic [7:0]            ld_idx_wide;
    logic [SLOT_W-1:0]     ld_slot;
    logic [63:0]           ld_val_wide;
    logic                  ld_ok;
    logic                  ram_wr;

    assign ld_slot_wide = 8'(s_slot);
    assign ld_idx_wide  = 8'(s_option_index);
    assign ld_slot      = ld_slot_wide[SLOT_W-1:0];
    assign ld_val_wide  = 64'(s_option_value);
    assign ld_ok        = (int'(s_slot) < MAX_SLOTS) && (int'(s_option_index) < MAX_OPTIONS);
    assign ram_wr       = cmd.load_wr && ld_ok;

    // Read address: chosen option of the scanned slot.
    logic [DIGIT_W-1:0]    ci_digit;
    logic [7:0]            ci_digit_wide;
    logic                  ci_oob;
    logic [ADDR_W-1:0]     rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;
    logic [VALUE_BITS-1:0] rd_val;

    assign ci_digit      = digit_reg[ci_reg];
    assign ci_digit_wide = 8'(ci_digit);
    assign ci_oob        = (int'(ci_digit) >= MAX_OPTIONS);
    assign rd_addr       = {ci_reg, ci_digit_wide[OPT_W-1:0]};
    assign rd_val        = rd_oob_reg ? '0 : ram_rd_data;

    dce_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_wr),
        .wr_addr({ld_slot, ld_idx_wide[OPT_W-1:0]}),
        .wr_data(ld_val_wide[VALUE_BITS-1:0]),
        .rd_en  (cmd.rd_issue),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    // Status: empty slot detection, carry test and duplicate compare.
    logic any_zero;
    logic dup_any;

    always_comb begin
        any_zero = 1'b0;
        dup_any  = 1'b0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if ((s < int'(n_act)) && (count_reg[s] == '0)) begin
                any_zero = 1'b1;
            end
            if ((s < int'(ci_reg)) && (val_reg[s] == rd_val)) begin
                dup_any = 1'b1;
            end
        end
    end

    assign status.any_empty = (n_act == '0) || any_zero;
    assign status.digit_ovf = (digit_reg[p_reg] >= count_reg[p_reg]);
    assign status.p_zero    = (p_reg == '0);
    assign status.dup_hit   = dup_any;
    assign status.ci_last   = (ci_reg == n_last);
    assign status.done      = done_reg;
    assign status.out_free  = !m_valid || m_ready;
    assign status.emit_last = done_reg || (n_act == '0) || (es_reg == n_last);

    // Option counts.
    always_comb begin
        count_next = count_reg;
        if (ram_wr && s_closes_slot) begin
            count_next[ld_slot] = OPT_CNT_W'(s_option_index) + OPT_CNT_W'(1);
        end
    end

    // Odometer digits and the step pointer.
    always_comb begin
        digit_next = digit_reg;
        p_next     = p_reg;
        priority if (cmd.start_init || cmd.wrap) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                digit_next[k] = '0;
            end
        end else if (cmd.step) begin
            digit_next[p_reg] = digit_reg[p_reg] + DIGIT_W'(1);
            for (int k = 0; k < MAX_SLOTS; k++) begin
                if ((k > int'(p_reg)) && (k < int'(n_act))) begin
                    digit_next[k] = '0;
                end
            end
        end else if (cmd.carry) begin
            digit_next[p_reg] = '0;
            digit_next[p_dec] = digit_reg[p_dec] + DIGIT_W'(1);
            p_next            = p_dec;
        end else begin
            // Digits hold.
        end
        if (cmd.adv_init) begin
            p_next = n_last;
        end else if (cmd.dup_to_p) begin
            p_next = ci_reg;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= CFG_W'(1);
            done_reg       <= 1'b1;
            iter_reg       <= '0;
            p_reg          <= '0;
            ci_reg         <= '0;
            es_reg         <= '0;
            m_valid        <= 1'b0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                count_reg[s] <= '0;
                digit_reg[s] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            digit_reg <= digit_next;
            p_reg     <= p_next;
            if (cmd.set_done) begin
                done_reg <= 1'b1;
            end else if (cmd.clr_done) begin
                done_reg <= 1'b0;
            end
            // Advance counter saturates at all ones.
            if (cmd.start_init) begin
                iter_reg <= '0;
            end else if (cmd.adv_init && (iter_reg != '1)) begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (cmd.ci_clr) begin
                ci_reg <= '0;
            end else if (cmd.cmp_take) begin
                ci_reg <= ci_reg + SLOT_W'(1);
            end
            if (cmd.emit_clr) begin
                es_reg <= '0;
            end else if (cmd.emit_load) begin
                es_reg <= es_reg + SLOT_W'(1);
            end
            if (cmd.emit_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Scan values and the out-of-range read flag.
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_oob_reg <= ci_oob;
        end
        if (cmd.cmp_take) begin
            val_reg[ci_reg] <= rd_val;
        end
    end

    // Output payload register.
    logic [7:0]  es_wide;
    logic [7:0]  es_digit_wide;
    logic [63:0] es_val_wide;

    assign es_wide       = 8'(es_reg);
    assign es_digit_wide = 8'(digit_reg[es_reg]);
    assign es_val_wide   = 64'(val_reg[es_reg]);

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_iteration_count <= iter_reg;
            if (done_reg || (n_act == '0)) begin
                m_out_slot     <= '0;
                m_chosen_index <= '0;
                m_chosen_value <= '0;
                m_last_of_run  <= 1'b1;
                m_exhausted    <= 1'b1;
            end else begin
                m_out_slot     <= es_wide[SLOT_FLD_W-1:0];
                m_chosen_index <= es_digit_wide[INDEX_W-1:0];
                m_chosen_value <= es_val_wide[OUT_VAL_W-1:0];
                m_last_of_run  <= (es_reg == n_last);
                m_exhausted    <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/distinct_choice_enumerator_core.sv
// Top level of the distinct choice enumerator: controller, datapath and ports.
//
//   Channel   Direction  Handshake          Carries
//   s_*       in         s_valid/s_ready    action, slot, option index, value, close flag
//   m_*       out        m_valid/m_ready    slot, chosen index and value, last, exhausted, count
//   cfg_*     in         cfg_wr_en          slot_count register, written with no wait
//
// A load is written as it is accepted. A start clears the digits and scans the all-zero
// assignment; each duplicate scan reads the option table once per slot. An advance steps the
// last digit, carries one digit at a time toward slot zero, then scans; a duplicate ends the
// scan early and restarts stepping at its slot with a rescan, so its time depends on the table
// contents. Results then leave one per cycle while m_ready is high. One transaction is worked
// on at a time; a stalled m_ready holds the output register. Reset is synchronous, active low.
module distinct_choice_enumerator_core #(
    parameter int MAX_SLOTS   = 8,
    parameter int MAX_OPTIONS = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dce_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dce_pkg::ACTION_W-1:0]    s_action,
    input  logic [dce_pkg::SLOT_FLD_W-1:0]  s_slot,
    input  logic [dce_pkg::INDEX_W-1:0]     s_option_index,
    input  logic [dce_pkg::OUT_VAL_W-1:0]   s_option_value,
    input  logic                            s_closes_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dce_pkg::SLOT_FLD_W-1:0]  m_out_slot,
    output logic [dce_pkg::INDEX_W-1:0]     m_chosen_index,
    output logic [dce_pkg::OUT_VAL_W-1:0]   m_chosen_value,
    output logic                            m_last_of_run,
    output logic                            m_exhausted,
    output logic [dce_pkg::ITER_W-1:0]      m_iteration_count
);
    import dce_pkg::*;

    dce_cmd_t    cmd;
    dce_status_t status;

    // Sequencing.
    dce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .status  (status),
        .cmd     (cmd)
    );

    // Storage, odometer and output register.
    dce_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_OPTIONS(MAX_OPTIONS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_slot           (s_slot),
        .s_option_index   (s_option_index),
        .s_option_value   (s_option_value),
        .s_closes_slot    (s_closes_slot),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_slot       (m_out_slot),
        .m_chosen_index   (m_chosen_index),
        .m_chosen_value   (m_chosen_value),
        .m_last_of_run    (m_last_of_run),
        .m_exhausted      (m_exhausted),
        .m_iteration_count(m_iteration_count)
    );

endmodule

FILE: dv/distinct_choice_enumerator_core_tb.sv
// Self-checking testbench for the distinct choice enumerator core: directed table, then random phases.
module distinct_choice_enumerator_core_tb;

    import dce_pkg::*;

    localparam int MAX_SLOTS     = 8;
    localparam int MAX_OPTIONS   = 16;
    localparam int VALUE_BITS    = 16;
    localparam int NUM_ROWS      = 25;
    localparam int RANDOM_ITEMS  = 90;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 300;

    // The one action code that the package leaves unnamed; the block ignores it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One input transaction.
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [SLOT_FLD_W-1:0] slot;
        logic [INDEX_W-1:0]    index;
        logic [OUT_VAL_W-1:0]  value;
        logic                  closes;
    } request_t;

    // One result transaction: a slot of an assignment, or an exhausted answer.
    typedef struct packed {
        logic [SLOT_FLD_W-1:0] slot;
        logic [INDEX_W-1:0]    index;
        logic [OUT_VAL_W-1:0]  value;
        logic                  last;
        logic                  exhausted;
        logic [ITER_W-1:0]     count;
    } choice_t;

    // A row of the directed table: a register write or a transaction.
    typedef struct packed {
        logic             is_cfg;
        logic [CFG_W-1:0] cfg_value;
        request_t         req;
        logic             typed;        // the row carries its own exhausted answer
        logic [ITER_W-1:0] typed_count;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action;
    logic [SLOT_FLD_W-1:0] s_slot;
    logic [INDEX_W-1:0]    s_option_index;
    logic [OUT_VAL_W-1:0]  s_option_value;
    logic                  s_closes_slot;
    logic                  m_valid;
    logic                  m_ready;
    logic [SLOT_FLD_W-1:0] m_out_slot;
    logic [INDEX_W-1:0]    m_chosen_index;
    logic [OUT_VAL_W-1:0]  m_chosen_value;
    logic                  m_last_of_run;
    logic                  m_exhausted;
    logic [ITER_W-1:0]     m_iteration_count;

    distinct_choice_enumerator_core #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_OPTIONS(MAX_OPTIONS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_slot           (s_slot),
        .s_option_index   (s_option_index),
        .s_option_value   (s_option_value),
        .s_closes_slot    (s_closes_slot),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_slot       (m_out_slot),
        .m_chosen_index   (m_chosen_index),
        .m_chosen_value   (m_chosen_value),
        .m_last_of_run    (m_last_of_run),
        .m_exhausted      (m_exhausted),
        .m_iteration_count(m_iteration_count)
    );

    // Shadow of the block: option table, per-slot counts, odometer and counter.
    logic [OUT_VAL_W-1:0] opt_value   [MAX_SLOTS][MAX_OPTIONS];
    bit                   opt_written [MAX_SLOTS][MAX_OPTIONS];
    logic [OPT_CNT_W-1:0] opt_count   [MAX_SLOTS];
    int unsigned          digit       [MAX_SLOTS];
    bit                   run_over;
    logic [ITER_W-1:0]    adv_count;
    logic [CFG_W-1:0]     slot_count_reg;

    choice_t   expected_choices[$];
    int        failures;
    int        items_sent;
    bit        offering;        // s_valid as last driven by the sender
    bit        sender_quiet;
    bit        hold_request;
    dir_row_t  dir_table [NUM_ROWS];

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    function automatic int active_slots();
        return (slot_count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_reg);
    endfunction

    function automatic logic [OUT_VAL_W-1:0] choice_value(int s);
        if (digit[s] >= MAX_OPTIONS) return '0;
        return opt_value[s][digit[s]];
    endfunction

    function automatic bit slot_missing(int n);
        int s;
        if (n == 0) return 1'b1;
        for (s = 0; s < n; s++)
            if (opt_count[s] == 0) return 1'b1;
        return 1'b0;
    endfunction

    // First slot whose value repeats an earlier slot, or n when all differ.
    function automatic int first_repeat(int n);
        int i, j;
        for (i = 1; i < n; i++)
            for (j = 0; j < i; j++)
                if (choice_value(i) == choice_value(j)) return i;
        return n;
    endfunction

    // Steps the odometer to the next assignment with all values distinct; a repeat
    // at slot i rules out the whole prefix, so stepping resumes at that slot.
    function automatic void advance_odometer();
        int n, p, k, hit;
        n = active_slots();
        if (adv_count != '1) adv_count = adv_count + 1;
        if (slot_missing(n)) begin
            run_over = 1'b1;
            return;
        end
        p = n - 1;
        while (1'b1) begin
            digit[p]++;
            for (k = p + 1; k < n; k++) digit[k] = 0;
            while (p >= 0) begin
                if (digit[p] < opt_count[p]) break;
                digit[p] = 0;
                p--;
                if (p >= 0) digit[p]++;
            end
            if (p < 0) begin
                run_over = 1'b1;
                for (k = 0; k < MAX_SLOTS; k++) digit[k] = 0;
                return;
            end
            hit = first_repeat(n);
            if (hit >= n) return;
            p = hit;
        end
    endfunction

    function automatic void emit_choices(ref choice_t outs[$]);
        int n, s;
        n = active_slots();
        if (run_over || n == 0) begin
            outs.push_back('{3'd0, 4'd0, 16'd0, 1'b1, 1'b1, adv_count});
            return;
        end
        for (s = 0; s < n; s++)
            outs.push_back('{3'(s), 4'(digit[s]), choice_value(s), (s == n - 1), 1'b0,
                             adv_count});
    endfunction

    // Expected results of one accepted transaction; updates the shadow state.
    function automatic void predict_choices(request_t rq, ref choice_t outs[$]);
        int n, s;
        case (rq.action)
            ACT_LOAD: begin
                opt_value[rq.slot][rq.index]   = rq.value;
                opt_written[rq.slot][rq.index] = 1'b1;
                if (rq.closes) opt_count[rq.slot] = OPT_CNT_W'(rq.index + 1);
            end
            ACT_START: begin
                n = active_slots();
                for (s = 0; s < MAX_SLOTS; s++) digit[s] = 0;
                adv_count = '0;
                if (slot_missing(n)) begin
                    run_over = 1'b1;
                end else begin
                    run_over = 1'b0;
                    if (first_repeat(n) < n) advance_odometer();
                end
                emit_choices(outs);
            end
            ACT_NEXT: begin
                if (!run_over) advance_odometer();
                emit_choices(outs);
            end
            default: ;
        endcase
    endfunction

    // A slot may only be closed at an index whose lower entries all hold values.
    function automatic bit prefix_written(int s, int k);
        int i;
        for (i = 0; i < k; i++)
            if (!opt_written[s][i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [OUT_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t txn_row(logic [ACTION_W-1:0] a, int s, int i,
                                         logic [OUT_VAL_W-1:0] v, bit c, bit typed,
                                         logic [ITER_W-1:0] n);
        dir_row_t row;
        row             = '0;
        row.req.action  = a;
        row.req.slot    = 3'(s);
        row.req.index   = 4'(i);
        row.req.value   = v;
        row.req.closes  = c;
        row.typed       = typed;
        row.typed_count = n;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_W-1:0] v);
        dir_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_value = v;
        return row;
    endfunction

    // Offers one transaction after a random gap and records its expected results.
    task automatic send_request(request_t rq, bit typed = 1'b0, logic [ITER_W-1:0] n = '0);
        int gap;
        choice_t outs[$];
        gap = pick_gap();
        if (gap > 0) begin
            if (offering) s_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        offering        = 1'b1;
        s_action       <= rq.action;
        s_slot         <= rq.slot;
        s_option_index <= rq.index;
        s_option_value <= rq.value;
        s_closes_slot  <= rq.closes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_choices(rq, outs);
        if (typed) expected_choices.push_back('{3'd0, 4'd0, 16'd0, 1'b1, 1'b1, n});
        else foreach (outs[i]) expected_choices.push_back(outs[i]);
        if (rq.action != ACT_UNUSED) items_sent++;
    endtask

    // Stops offering and waits until the block has nothing left to deliver.
    task automatic drain_results();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
            @(posedge aclk);
        end
        while (expected_choices.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slot_count(logic [CFG_W-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        slot_count_reg = v;
    endtask

    // One random phase: pick a slot count, load the option lists, start, then step.
    task automatic random_phase(int phase_no);
        int pick, n_eff, opts, nexts, s, k, j;
        logic [CFG_W-1:0] cfg_v;
        request_t rq;
        pick = $urandom_range(0, 9);
        if (pick == 0) cfg_v = 4'd0;
        else if (pick == 1) cfg_v = 4'd15;
        else if (pick == 2) cfg_v = 4'd8;
        else cfg_v = 4'($urandom_range(1, 5));
        drain_results();
        write_slot_count(cfg_v);
        sender_quiet = ($urandom_range(0, 3) == 0);
        n_eff = (cfg_v > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_v);

        // Wide assignments keep short lists so that the search stays short.
        for (s = 0; s < n_eff; s++) begin
            if (n_eff > 5 || $urandom_range(0, 9) < 8) begin
                opts = (n_eff > 5) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                for (k = 0; k < opts; k++) begin
                    rq = '{ACT_LOAD, 3'(s), 4'(k), pick_value(), (k == opts - 1)};
                    send_request(rq);
                end
            end
        end

        rq = '{ACT_START, 3'($urandom), 4'($urandom), 16'($urandom), 1'($urandom)};
        send_request(rq);
        if (phase_no == 2) hold_request = 1'b1;

        // Steps, mixed with table changes in mid-run, ignored codes and pauses.
        nexts = (phase_no == 2) ? 6 : $urandom_range(1, 6);
        for (j = 0; j < nexts; j++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                s  = $urandom_range(0, MAX_SLOTS - 1);
                k  = $urandom_range(0, MAX_OPTIONS - 1);
                rq = '{ACT_LOAD, 3'(s), 4'(k), 16'($urandom),
                       ($urandom_range(0, 1) == 1) && prefix_written(s, k)};
                send_request(rq);
            end else if (pick == 3) begin
                rq = '{ACT_UNUSED, 3'($urandom), 4'($urandom), 16'($urandom), 1'($urandom)};
                send_request(rq);
            end
            if (pick == 4 || (phase_no == 1 && j == 0)) drain_results();
            rq = '{ACT_NEXT, 3'($urandom), 4'($urandom), 16'($urandom), 1'($urandom)};
            send_request(rq);
        end
    endtask

    // Result side: random back-pressure and comparison against the expected queue.
    initial begin : result_side
        int stall_left, mode_left;
        bit rx_quiet;
        choice_t got, want;
        m_ready    = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        rx_quiet   = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_out_slot, m_chosen_index, m_chosen_value, m_last_of_run,
                        m_exhausted, m_iteration_count};
                if (expected_choices.size() == 0) begin
                    $display("%0t: result mismatch: expected none, ", $time,
                             "got slot %0d index %0d value %h ", got.slot, got.index,
                             got.value,
                             "last %0b exhausted %0b count %0d", got.last, got.exhausted,
                             got.count);
                    failures++;
                end else begin
                    want = expected_choices.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch: ", $time,
                                 "expected slot %0d index %0d value %h ", want.slot,
                                 want.index, want.value,
                                 "last %0b exhausted %0b count %0d, ", want.last,
                                 want.exhausted, want.count,
                                 "got slot %0d index %0d value %h ", got.slot, got.index,
                                 got.value,
                                 "last %0b exhausted %0b count %0d", got.last,
                                 got.exhausted, got.count);
                        failures++;
                    end
                end
            end

            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_quiet  = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end

            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
                m_ready   <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Request side: reset, directed table, random phases, final verdict.
    initial begin : request_side
        int r, s, k, phase_no;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_action       = '0;
        s_slot         = '0;
        s_option_index = '0;
        s_option_value = '0;
        s_closes_slot  = 1'b0;
        offering       = 1'b0;
        sender_quiet   = 1'b0;
        hold_request   = 1'b0;
        failures       = 0;
        items_sent     = 0;

        // Shadow state after reset.
        for (s = 0; s < MAX_SLOTS; s++) begin
            opt_count[s] = '0;
            digit[s]     = 0;
            for (k = 0; k < MAX_OPTIONS; k++) begin
                opt_value[s][k]   = '0;
                opt_written[s][k] = 1'b0;
            end
        end
        run_over       = 1'b1;
        adv_count      = '0;
        slot_count_reg = 4'd1;

        dir_table = '{
            // Step before any start, then start with slot zero still empty.
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b1, 32'd0),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b1, 32'd0),
            txn_row(ACT_UNUSED, 7, 15, 16'hFFFF, 1'b1, 1'b0, 32'd0),
            // One slot with two options, run to exhaustion and past it.
            txn_row(ACT_LOAD,   0, 0, 16'hFFFF, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_LOAD,   0, 1, 16'h0000, 1'b1, 1'b0, 32'd0),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b1, 32'd2),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b1, 32'd2),
            // Two slots whose first choices collide, so start has to skip.
            cfg_row(4'd2),
            txn_row(ACT_LOAD,   1, 0, 16'hFFFF, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_LOAD,   1, 1, 16'h1234, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_LOAD,   1, 2, 16'h0000, 1'b1, 1'b0, 32'd0),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_LOAD,   7, 15, 16'hA5A5, 1'b0, 1'b0, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b0, 32'd0),
            // Slot count above the slot limit, with the upper slots empty.
            cfg_row(4'd15),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b1, 32'd0),
            // No active slots at all.
            cfg_row(4'd0),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b1, 32'd0),
            txn_row(ACT_NEXT,   0, 0, 16'h0000, 1'b0, 1'b1, 32'd0),
            cfg_row(4'd1),
            txn_row(ACT_START,  0, 0, 16'h0000, 1'b0, 1'b0, 32'd0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < NUM_ROWS; r++) begin
            if (dir_table[r].is_cfg) begin
                drain_results();
                write_slot_count(dir_table[r].cfg_value);
            end else begin
                send_request(dir_table[r].req, dir_table[r].typed, dir_table[r].typed_count);
            end
        end

        items_sent = 0;
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            random_phase(phase_no);
            phase_no++;
        end

        drain_results();
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
